>>> rtl/mwdg_pkg.sv
// Shared types and constants of the masked window dilation gate.
// Used by the channel interfaces, the top level and the port checker.
`default_nettype none

package mwdg_pkg;

  // Default build parameters of the top level
  localparam int unsigned HALF_X_DEF    = 2;
  localparam int unsigned HALF_Y_DEF    = 3;
  localparam int unsigned MAX_WIDTH_DEF = 2048;

  // Largest frame dimension the counters cover
  localparam int unsigned IMG_DIM_CAP = 2048;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_FLD_W  = 11;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_REGION_LEFT   = 3'd2,
    CFG_REGION_TOP    = 3'd3,
    CFG_REGION_WIDTH  = 3'd4,
    CFG_REGION_HEIGHT = 3'd5
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [DIM_W-1:0]     IMAGE_WIDTH_RST   = 12'd640;
  localparam logic [DIM_W-1:0]     IMAGE_HEIGHT_RST  = 12'd480;
  localparam logic [POS_FLD_W-1:0] REGION_LEFT_RST   = 11'd0;
  localparam logic [POS_FLD_W-1:0] REGION_TOP_RST    = 11'd0;
  localparam logic [DIM_W-1:0]     REGION_WIDTH_RST  = 12'd0;
  localparam logic [DIM_W-1:0]     REGION_HEIGHT_RST = 12'd0;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0]    out_byte;
    logic [POS_FLD_W-1:0] out_row;
    logic [POS_FLD_W-1:0] out_col;
    logic                 frame_last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/mwdg_if.sv
// Valid/ready channel interfaces for pixel beats in and result beats out.
// Field widths come from mwdg_pkg.
`default_nettype none

interface mwdg_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic [mwdg_pkg::BYTE_W-1:0]   mask_byte;
  logic [mwdg_pkg::BYTE_W-1:0]   color_byte;
  logic                          padding;

  modport source (output valid, mask_byte, color_byte, padding, input ready);
  modport sink   (input valid, mask_byte, color_byte, padding, output ready);
endinterface

interface mwdg_pix_out_if;
  logic                           valid;
  logic                           ready;
  logic [mwdg_pkg::BYTE_W-1:0]    out_byte;
  logic [mwdg_pkg::POS_FLD_W-1:0] out_row;
  logic [mwdg_pkg::POS_FLD_W-1:0] out_col;
  logic                           frame_last;

  modport source (output valid, out_byte, out_row, out_col, frame_last, input ready);
  modport sink   (input valid, out_byte, out_row, out_col, frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/mwdg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents.
`default_nettype none

module mwdg_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read in the same edge, read sees the old entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/masked_window_dilation_gate.sv
// Masked window dilation gate: top level with line store, mask delay and result queue.
// Depends on mwdg_pkg, mwdg_pix_in_if / mwdg_pix_out_if and mwdg_ram.
//
//   channel   dir   handshake             payload
//   pix_in    in    valid / ready         mask_byte, color_byte, padding
//   pix_out   out   valid / ready         out_byte, out_row, out_col, frame_last
//   cfg       in    cfg_we_i              cfg_idx_i, cfg_data_i (write only)
//
// One pixel beat is taken per clock while the result queue has room. Each beat passes stage 0
// and stage 1 before its result enters the result queue; the line store read-modify-write (one read, one write per
// cycle, same-column back-to-back accesses forwarded) and the mask delay RAM keep that pace.
// pix_in.ready depends only on the fill of the three-entry result queue and the stage
// after the RAM reads, so a stalled pix_out never reaches pix_in combinationally.
// Reset clears counters, window and queue at once; the RAMs need no clearing pass.
`default_nettype none

module masked_window_dilation_gate #(
  parameter int unsigned HALF_X    = mwdg_pkg::HALF_X_DEF,
  parameter int unsigned HALF_Y    = mwdg_pkg::HALF_Y_DEF,
  parameter int unsigned MAX_WIDTH = mwdg_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mwdg_pix_in_if.sink                       pix_in,
  mwdg_pix_out_if.source                    pix_out,
  input  logic                              cfg_we_i,
  input  logic [mwdg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mwdg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned DIM_W     = mwdg_pkg::DIM_W;
  localparam int unsigned PF_W      = mwdg_pkg::POS_FLD_W;
  localparam int unsigned WCAP      = (MAX_WIDTH < mwdg_pkg::IMG_DIM_CAP) ?
                                      MAX_WIDTH : mwdg_pkg::IMG_DIM_CAP;
  localparam int unsigned COL_W     = $clog2(WCAP);
  localparam int unsigned CA_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROWS_KEPT = 2 * HALF_Y;
  localparam int unsigned LINE_W    = (ROWS_KEPT > 0) ? ROWS_KEPT : 1;
  localparam int unsigned TAPS      = 2 * HALF_X + 1;
  localparam int unsigned LAT_MAX   = HALF_Y * WCAP + HALF_X;
  localparam int unsigned LAT_W     = ($clog2(LAT_MAX + 1) > 0) ? $clog2(LAT_MAX + 1) : 1;
  localparam int unsigned MD_DEPTH  = 2 ** LAT_W;
  localparam int unsigned POS_W     = $clog2(WCAP * mwdg_pkg::IMG_DIM_CAP + LAT_MAX + 1);
  localparam int unsigned Q_DEPTH   = 3;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic              in_rect;
    logic              cbit;
    logic              mbit;
    logic              lat0;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] vmask;
    logic [TAPS-1:0]   tapok;
    logic [PF_W-1:0]   orow;
    logic [PF_W-1:0]   ocol;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_q, height_q, rwidth_q, rheight_q;
  logic [PF_W-1:0]  left_q, top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= mwdg_pkg::IMAGE_WIDTH_RST;
      height_q  <= mwdg_pkg::IMAGE_HEIGHT_RST;
      left_q    <= mwdg_pkg::REGION_LEFT_RST;
      top_q     <= mwdg_pkg::REGION_TOP_RST;
      rwidth_q  <= mwdg_pkg::REGION_WIDTH_RST;
      rheight_q <= mwdg_pkg::REGION_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (mwdg_pkg::cfg_idx_e'(cfg_idx_i))
        mwdg_pkg::CFG_IMAGE_WIDTH:   width_q   <= cfg_data_i[DIM_W-1:0];
        mwdg_pkg::CFG_IMAGE_HEIGHT:  height_q  <= cfg_data_i[DIM_W-1:0];
        mwdg_pkg::CFG_REGION_LEFT:   left_q    <= cfg_data_i[PF_W-1:0];
        mwdg_pkg::CFG_REGION_TOP:    top_q     <= cfg_data_i[PF_W-1:0];
        mwdg_pkg::CFG_REGION_WIDTH:  rwidth_q  <= cfg_data_i[DIM_W-1:0];
        mwdg_pkg::CFG_REGION_HEIGHT: rheight_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size and derive the result delay
  logic [DIM_W-1:0] width_eff, height_eff, wm1, hm1;
  logic [LAT_W-1:0] lat;

  always_comb begin
    width_eff = width_q;
    if (width_q == '0) begin
      width_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(WCAP)) begin
      width_eff = DIM_W'(WCAP);
    end
    height_eff = height_q;
    if (height_q == '0) begin
      height_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(mwdg_pkg::IMG_DIM_CAP)) begin
      height_eff = DIM_W'(mwdg_pkg::IMG_DIM_CAP);
    end
    wm1 = width_eff - DIM_W'(1);
    hm1 = height_eff - DIM_W'(1);
    lat = LAT_W'(HALF_Y * width_eff + HALF_X);
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept the beat, advance counters, issue RAM reads
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] a_q, a_d;            // input row, saturating
  logic [COL_W-1:0] b_q, b_d;            // input column
  logic [POS_W-1:0] s_q, s_d;            // input position in frame
  logic [PF_W-1:0]  r_q, r_d;            // result row
  logic [COL_W-1:0] c_q, c_d;            // result column
  logic [LAT_W-1:0] wp_q, wp_d;          // mask delay write pointer

  logic s1_valid_q;
  s1_t  s1_q, s1_d;
  logic [1:0] cnt_q;
  logic       in_ready, in_fire, skip, step, live, emit, last;
  logic [12:0] cx, c13, r13, left13, top13;
  logic [2:0]  fill;

  // Room for the beat in the result queue, counting the one in stage 1
  assign fill     = 3'(cnt_q) + 3'(s1_valid_q);
  assign in_ready = fill < 3'(Q_DEPTH);
  assign in_fire  = pix_in.valid && in_ready;
  assign pix_in.ready = in_ready;

  always_comb begin
    skip = pix_in.padding && (a_q == '0) && (b_q == '0) && (r_q == '0) && (c_q == '0);
    step = in_fire && !skip;
    live = (a_q < height_eff) && !pix_in.padding;
    emit = s_q >= POS_W'(lat);
    last = emit && ((DIM_W'(r_q) > hm1) ||
                    ((DIM_W'(r_q) == hm1) && (DIM_W'(c_q) >= wm1)));

    // Sweep counters
    a_d = a_q;
    b_d = b_q;
    s_d = s_q + POS_W'(1);
    if (DIM_W'(b_q) + DIM_W'(1) >= width_eff) begin
      b_d = '0;
      if (a_q != '1) begin
        a_d = a_q + DIM_W'(1);
      end
    end else begin
      b_d = b_q + COL_W'(1);
    end

    // Result position
    r_d = r_q;
    c_d = c_q;
    if (emit) begin
      if (DIM_W'(c_q) + DIM_W'(1) >= width_eff) begin
        c_d = '0;
        r_d = r_q + PF_W'(1);
      end else begin
        c_d = c_q + COL_W'(1);
      end
    end

    // Frame end clears the sweep
    if (last) begin
      a_d = '0;
      b_d = '0;
      s_d = '0;
      r_d = '0;
      c_d = '0;
    end
    wp_d = wp_q + LAT_W'(1);

    // Payload for stage 1
    c13    = 13'(c_q);
    r13    = 13'(r_q);
    left13 = 13'(left_q);
    top13  = 13'(top_q);
    cx     = c13 + 13'(HALF_X);

    s1_d.emit    = emit;
    s1_d.last    = last;
    s1_d.in_rect = (c13 >= left13) && (c13 < left13 + 13'(rwidth_q)) &&
                   (r13 >= top13) && (r13 < top13 + 13'(rheight_q));
    s1_d.cbit    = live && (pix_in.color_byte == mwdg_pkg::FULL_BYTE);
    s1_d.mbit    = live && (pix_in.mask_byte == mwdg_pkg::FULL_BYTE);
    s1_d.lat0    = lat == '0;
    s1_d.col     = b_q;
    s1_d.orow    = r_q;
    s1_d.ocol    = PF_W'(c_q);
    // Rows above that belong to this frame
    for (int j = 1; j <= LINE_W; j++) begin
      s1_d.vmask[j-1] = (j <= ROWS_KEPT) && (a_q >= DIM_W'(j)) &&
                        ((a_q - DIM_W'(j)) < height_eff);
    end
    // Window columns that fall inside the image
    for (int i = 0; i < TAPS; i++) begin
      s1_d.tapok[i] = (cx >= 13'(i)) && ((cx - 13'(i)) < 13'(width_eff));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      b_q  <= '0;
      s_q  <= '0;
      r_q  <= '0;
      c_q  <= '0;
      wp_q <= '0;
    end else if (step) begin
      a_q  <= a_d;
      b_q  <= b_d;
      s_q  <= s_d;
      r_q  <= r_d;
      c_q  <= c_d;
      wp_q <= wp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [LINE_W-1:0] line_rdata, line_wdata, line_rd;
  logic [LINE_W:0]   line_shift;
  logic              mask_rdata;
  logic              fwd_hit_q;
  logic [LINE_W-1:0] fwd_data_q;

  // Per column: color bits of the last rows, newest in bit 0
  mwdg_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (CA_W'(s1_q.col)),
    .wdata_i (line_wdata),
    .re_i    (step),
    .raddr_i (CA_W'(b_q)),
    .rdata_o (line_rdata)
  );

  // Mask bits delayed by the window latency
  mwdg_ram #(
    .WIDTH (1),
    .DEPTH (MD_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (wp_q),
    .wdata_i (s1_d.mbit),
    .re_i    (step),
    .raddr_i (wp_q - lat),
    .rdata_o (mask_rdata)
  );

  // Forward the write-back when the next beat reads the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= s1_valid_q && (s1_q.col == b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= line_wdata;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: vertical OR, column window, gate
  // ---------------------------------------------------------------------------
  logic [TAPS-1:0] win_q, win_new;
  logic [TAPS:0]   win_shift;
  logic            vbit, any_hit, mflag;
  mwdg_pkg::result_t res;

  always_comb begin
    line_rd    = fwd_hit_q ? fwd_data_q : line_rdata;
    vbit       = s1_q.cbit || (|(line_rd & s1_q.vmask));
    line_shift = {line_rd, s1_q.cbit};
    line_wdata = line_shift[LINE_W-1:0];
    win_shift  = {win_q, vbit};
    win_new    = win_shift[TAPS-1:0];
    any_hit    = |(win_new & s1_q.tapok);
    mflag      = s1_q.lat0 ? s1_q.mbit : mask_rdata;

    res.out_byte   = (mflag && any_hit && s1_q.in_rect) ? mwdg_pkg::FULL_BYTE : '0;
    res.out_row    = s1_q.orow;
    res.out_col    = s1_q.ocol;
    res.frame_last = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      s1_valid_q <= step;
      if (s1_valid_q) begin
        win_q <= s1_q.last ? '0 : win_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  mwdg_pkg::result_t q_mem_q [Q_DEPTH];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic       push, pop;

  assign push = s1_valid_q && s1_q.emit;
  assign pop  = pix_out.valid && pix_out.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= res;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == 2'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 2'd1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign pix_out.valid      = cnt_q != '0;
  assign pix_out.out_byte   = q_mem_q[rd_ptr_q].out_byte;
  assign pix_out.out_row    = q_mem_q[rd_ptr_q].out_row;
  assign pix_out.out_col    = q_mem_q[rd_ptr_q].out_col;
  assign pix_out.frame_last = q_mem_q[rd_ptr_q].frame_last;

endmodule

`default_nettype wire

>>> rtl/mwdg_checker.sv
// Port checker for the masked window dilation gate, bound to the top level.
// Depends on mwdg_pkg; watches the result channel only.
`default_nettype none

module mwdg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [mwdg_pkg::BYTE_W-1:0]    out_byte_i,
  input logic [mwdg_pkg::POS_FLD_W-1:0] out_row_i,
  input logic [mwdg_pkg::POS_FLD_W-1:0] out_col_i,
  input logic                           frame_last_i
);

  localparam int unsigned PF_W = mwdg_pkg::POS_FLD_W;

  logic            out_fire;
  logic            origin_q;
  logic [PF_W-1:0] prev_row_q, prev_col_q;

  assign out_fire = out_valid_i && out_ready_i;

  // Track the previous result beat and whether a frame starts next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q   <= 1'b1;
      prev_row_q <= '0;
      prev_col_q <= '0;
    end else if (out_fire) begin
      origin_q   <= frame_last_i;
      prev_row_q <= out_row_i;
      prev_col_q <= out_col_i;
    end
  end

  // Stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_byte_i, out_row_i, out_col_i, frame_last_i}))
    else $error("result beat changed while stalled");

  // Result is all ones or all zeros
  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_byte_i == mwdg_pkg::FULL_BYTE) || (out_byte_i == '0))
    else $error("result byte neither 0 nor 255");

  // A frame starts at the origin
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && origin_q |-> (out_row_i == '0) && (out_col_i == '0))
    else $error("frame does not start at row 0, column 0");

  // Raster order inside a frame
  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !origin_q |->
      ((out_row_i == prev_row_q) && (out_col_i == prev_col_q + PF_W'(1))) ||
      ((out_row_i == prev_row_q + PF_W'(1)) && (out_col_i == '0)))
    else $error("result beats out of raster order");

endmodule

bind masked_window_dilation_gate mwdg_checker u_mwdg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (pix_out.valid),
  .out_ready_i  (pix_out.ready),
  .out_byte_i   (pix_out.out_byte),
  .out_row_i    (pix_out.out_row),
  .out_col_i    (pix_out.out_col),
  .frame_last_i (pix_out.frame_last)
);

`default_nettype wire
